@@ design/weight_vector_gcd_normalizer_core_macros.svh @@
// ----------------------------------------------------------------------------
// Weight vector GCD normalizer assertion macros
// Shared property shorthands for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef WEIGHT_VECTOR_GCD_NORMALIZER_CORE_MACROS_SVH
`define WEIGHT_VECTOR_GCD_NORMALIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define WVGN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define WVGN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/wvgn_pkg.sv @@
// ----------------------------------------------------------------------------
// wvgn_pkg
// Shared types and constants of the weight vector GCD normalizer.
// ----------------------------------------------------------------------------
package wvgn_pkg;

    // Port widths fixed by the interface
    localparam int PORT_WEIGHT_W = 32;
    localparam int PORT_INDEX_W  = 6;

    // Normalization applies from this many stored weights on
    localparam int MIN_RUN       = 2;
    // A divisor must exceed this to change anything
    localparam int UNIT_DIVISOR  = 1;

    // Classification of one request, passed from front to back
    typedef struct packed {
        logic last;
        logic drop;
    } wvgn_ctl_t;

endpackage

@@ design/wvgn_queue.sv @@
// ----------------------------------------------------------------------------
// wvgn_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module wvgn_queue
#(
    parameter int DW = 34
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    output logic          valid,
    input  logic          pop,
    output logic [DW-1:0] pop_data
);

    logic [DW-1:0] entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign valid    = (cnt_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/wvgn_front.sv @@
// ----------------------------------------------------------------------------
// wvgn_front
// Accepts requests, tracks the run fill and marks requests past capacity.
// ----------------------------------------------------------------------------
module wvgn_front
    import wvgn_pkg::*;
#(
    parameter int MAX_WEIGHTS = 64,
    parameter int W           = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         last,
    input  logic [W-1:0] weight,
    input  logic         q_full,
    output logic         busy,
    output logic         push,
    output wvgn_ctl_t    push_ctl,
    output logic [W-1:0] push_weight
);

    localparam int CW = $clog2(MAX_WEIGHTS + 1);

    logic [CW-1:0] count_reg;
    logic          drop;

    assign busy        = q_full;
    assign push        = start && !q_full;
    assign drop        = (count_reg == CW'(MAX_WEIGHTS));
    assign push_ctl    = '{last: last, drop: drop};
    assign push_weight = weight;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            // Restart the fill at the end of a run
            if (last)
            begin
                count_reg <= '0;
            end
            else if (!drop)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

endmodule

@@ design/wvgn_back.sv @@
// ----------------------------------------------------------------------------
// wvgn_back
// Stores weights, runs the binary GCD per weight and emits the weights, divided when normalized.
// ----------------------------------------------------------------------------
module wvgn_back
    import wvgn_pkg::*;
#(
    parameter int MAX_WEIGHTS = 64,
    parameter int W           = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  wvgn_ctl_t                q_ctl,
    input  logic [W-1:0]             q_weight,
    output logic                     q_pop,
    output logic                     result_valid,
    output logic [PORT_INDEX_W-1:0]  index,
    output logic [PORT_WEIGHT_W-1:0] weight_out,
    output logic [PORT_WEIGHT_W-1:0] divisor,
    output logic                     changed,
    output logic                     overflow,
    output logic                     end_of_run
);

    localparam int CW = $clog2(MAX_WEIGHTS + 1);
    localparam int IW = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
    localparam int KW = $clog2(W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_READ,
        S_LOAD,
        S_DIV
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] count_reg;
    logic [W-1:0]  div_reg;
    logic          ovf_reg;
    logic          last_pend_reg;
    logic [W-1:0]  ga_reg;
    logic [W-1:0]  gb_reg;
    logic [KW-1:0] gk_reg;
    logic [IW-1:0] idx_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [KW-1:0] bit_reg;
    logic [W-1:0]  rd_data_reg;

    logic                     res_valid_reg;
    logic [PORT_INDEX_W-1:0]  res_index_reg;
    logic [PORT_WEIGHT_W-1:0] res_weight_reg;
    logic [PORT_WEIGHT_W-1:0] res_div_reg;
    logic                     res_changed_reg;
    logic                     res_ovf_reg;
    logic                     res_end_reg;

    logic [W-1:0]  store_mem [MAX_WEIGHTS];

    logic          wr_en;
    logic          gcd_done;
    logic [W:0]    g_sub;
    logic [W-1:0]  gcd_val;
    logic [W:0]    rem_sh;
    logic [W:0]    d_sub;
    logic          take;
    logic [W-1:0]  rem_new;
    logic [W-1:0]  quo_new;
    logic          norm;
    logic          last_item;
    logic          emit_now;
    logic [W-1:0]  emit_val;

    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign wr_en = q_pop && !q_ctl.drop;

    // Binary GCD step
    assign gcd_done = (ga_reg == '0) || (gb_reg == '0);
    assign g_sub    = {1'b0, ga_reg} - {1'b0, gb_reg};
    assign gcd_val  = W'((ga_reg | gb_reg) << gk_reg);

    // Restoring divide step
    assign rem_sh  = {rem_reg, quo_reg[W-1]};
    assign d_sub   = rem_sh - {1'b0, div_reg};
    assign take    = !d_sub[W];
    assign rem_new = take ? d_sub[W-1:0] : rem_sh[W-1:0];
    assign quo_new = {quo_reg[W-2:0], take};

    assign norm      = (count_reg >= CW'(MIN_RUN)) && (div_reg > W'(UNIT_DIVISOR));
    assign last_item = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign emit_now  = ((state_reg == S_LOAD) && !norm)
                    || ((state_reg == S_DIV) && (bit_reg == KW'(1)));
    assign emit_val  = (state_reg == S_DIV) ? quo_new : rd_data_reg;

    // Weight store: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[count_reg[IW-1:0]] <= q_weight;
        end
        rd_data_reg <= store_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            div_reg         <= '0;
            ovf_reg         <= 1'b0;
            last_pend_reg   <= 1'b0;
            ga_reg          <= '0;
            gb_reg          <= '0;
            gk_reg          <= '0;
            idx_reg         <= '0;
            rem_reg         <= '0;
            quo_reg         <= '0;
            bit_reg         <= '0;
            res_valid_reg   <= 1'b0;
            res_index_reg   <= '0;
            res_weight_reg  <= '0;
            res_div_reg     <= '0;
            res_changed_reg <= 1'b0;
            res_ovf_reg     <= 1'b0;
            res_end_reg     <= 1'b0;
        end
        else
        begin
            res_valid_reg <= emit_now;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_ctl.drop)
                        begin
                            ovf_reg <= 1'b1;
                            if (q_ctl.last)
                            begin
                                state_reg <= S_READ;
                            end
                        end
                        else
                        begin
                            count_reg     <= count_reg + CW'(1);
                            ga_reg        <= div_reg;
                            gb_reg        <= q_weight;
                            gk_reg        <= '0;
                            last_pend_reg <= q_ctl.last;
                            state_reg     <= S_GCD;
                        end
                    end
                end
                S_GCD:
                begin
                    if (gcd_done)
                    begin
                        div_reg   <= gcd_val;
                        state_reg <= last_pend_reg ? S_READ : S_IDLE;
                    end
                    else if (!ga_reg[0] && !gb_reg[0])
                    begin
                        ga_reg <= ga_reg >> 1;
                        gb_reg <= gb_reg >> 1;
                        gk_reg <= gk_reg + KW'(1);
                    end
                    else if (!ga_reg[0])
                    begin
                        ga_reg <= ga_reg >> 1;
                    end
                    else if (!gb_reg[0])
                    begin
                        gb_reg <= gb_reg >> 1;
                    end
                    else if (!g_sub[W])
                    begin
                        ga_reg <= g_sub[W-1:0];
                    end
                    else
                    begin
                        gb_reg <= gb_reg - ga_reg;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    if (norm)
                    begin
                        rem_reg   <= '0;
                        quo_reg   <= rd_data_reg;
                        bit_reg   <= KW'(W);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_new;
                    quo_reg <= quo_new;
                    bit_reg <= bit_reg - KW'(1);
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (emit_now)
            begin
                res_index_reg   <= PORT_INDEX_W'(idx_reg);
                res_weight_reg  <= PORT_WEIGHT_W'(emit_val);
                res_div_reg     <= PORT_WEIGHT_W'(div_reg);
                res_changed_reg <= norm;
                res_ovf_reg     <= ovf_reg;
                res_end_reg     <= last_item;
                if (last_item)
                begin
                    // Drop the run and start over empty
                    count_reg <= '0;
                    div_reg   <= '0;
                    ovf_reg   <= 1'b0;
                    idx_reg   <= '0;
                    state_reg <= S_IDLE;
                end
                else
                begin
                    idx_reg   <= idx_reg + IW'(1);
                    state_reg <= S_READ;
                end
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign index        = res_index_reg;
    assign weight_out   = res_weight_reg;
    assign divisor      = res_div_reg;
    assign changed      = res_changed_reg;
    assign overflow     = res_ovf_reg;
    assign end_of_run   = res_end_reg;

endmodule

@@ design/weight_vector_gcd_normalizer_core.sv @@
// ----------------------------------------------------------------------------
// weight_vector_gcd_normalizer_core
// Loads a weight vector, tracks its GCD and emits the normalized weights.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive weight and last with start high; the request is
//   taken at a rising edge where start is high and busy is low. busy rises
//   only when the two-entry request queue is full.
//   Each stored weight updates a running GCD with a binary GCD sequencer,
//   one shift or subtract per cycle (at most 32 bits are kept). A request
//   past MAX_WEIGHTS is dropped and sets the overflow flag of the run.
//   A request with last set starts the emission: one result per stored
//   weight, in load order. Each result takes a store read, plus the
//   restoring divider when the run is normalized (at least two weights
//   and a divisor above one). The divider and the GCD sequencer bound
//   the rate.
//   Result channel: result_valid is high for exactly one cycle per result;
//   the receiver cannot stall, so fields must be captured on that cycle.
//   end_of_run marks the final result, after which the run state is empty.
//   Reset clears the queue, the fill count, the divisor and the flags.
// ----------------------------------------------------------------------------
module weight_vector_gcd_normalizer_core
    import wvgn_pkg::*;
#(
    parameter int MAX_WEIGHTS = 64,
    parameter int WEIGHT_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] weight,
    input  logic        last,
    output logic        result_valid,
    output logic [5:0]  index,
    output logic [31:0] weight_out,
    output logic [31:0] divisor,
    output logic        changed,
    output logic        overflow,
    output logic        end_of_run
);

    // Kept weight width: the port caps it at 32 bits
    localparam int W  = (WEIGHT_BITS < PORT_WEIGHT_W) ? WEIGHT_BITS : PORT_WEIGHT_W;
    localparam int DW = W + $bits(wvgn_ctl_t);

    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          push;
    wvgn_ctl_t     push_ctl;
    logic [W-1:0]  push_weight;
    logic [DW-1:0] pop_data;
    wvgn_ctl_t     q_ctl;
    logic [W-1:0]  q_weight;

    // Front: take requests and mark those past capacity
    wvgn_front #(
        .MAX_WEIGHTS (MAX_WEIGHTS),
        .W           (W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .last        (last),
        .weight      (weight[W-1:0]),
        .q_full      (q_full),
        .busy        (busy),
        .push        (push),
        .push_ctl    (push_ctl),
        .push_weight (push_weight)
    );

    // Hold requests while the back end works
    wvgn_queue #(
        .DW (DW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ctl, push_weight}),
        .full      (q_full),
        .valid     (q_valid),
        .pop       (q_pop),
        .pop_data  (pop_data)
    );

    assign q_ctl    = wvgn_ctl_t'(pop_data[DW-1:W]);
    assign q_weight = pop_data[W-1:0];

    // Back: store, GCD, divide and emit
    wvgn_back #(
        .MAX_WEIGHTS (MAX_WEIGHTS),
        .W           (W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ctl        (q_ctl),
        .q_weight     (q_weight),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .index        (index),
        .weight_out   (weight_out),
        .divisor      (divisor),
        .changed      (changed),
        .overflow     (overflow),
        .end_of_run   (end_of_run)
    );

endmodule

@@ design/wvgn_checker.sv @@
// ----------------------------------------------------------------------------
// wvgn_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "weight_vector_gcd_normalizer_core_macros.svh"

module wvgn_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic [31:0] weight_out,
    input logic [31:0] divisor,
    input logic        changed
);

    // Every result needs a store read, so strobes never come back to back
    `WVGN_ASSERT_NEXT(a_strobe_gap, clk, rst_n, result_valid, !result_valid, "results back to back")

    // A changed vector always has a divisor above one
    `WVGN_ASSERT_NOW(a_changed_div, clk, rst_n, result_valid && changed, divisor > 32'd1, "changed with divisor not above one")

    // A zero divisor means all weights were zero and nothing was divided
    `WVGN_ASSERT_NOW(a_zero_div, clk, rst_n, result_valid && (divisor == 32'd0), (weight_out == 32'd0) && !changed, "zero divisor with nonzero weight")

endmodule

bind weight_vector_gcd_normalizer_core wvgn_checker u_wvgn_checker (.*);
